// File: rtl/rtu_pkg.sv
// Package for the interface rate tracker: shared types and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package rtu_pkg;

    localparam int DIV_NUM_W = 82;   // widest numerator: 64-bit delta times 204800
    localparam int DIV_DEN_W = 96;   // widest denominator: 32-bit time times 64-bit speed
    localparam int DIV_DS_W  = 128;  // shifted denominator inside the divider
    localparam int DIV_Q_W   = 65;   // 64 quotient bits plus the overflow bit
    localparam int DIV_CNT_W = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [19:0] MEGA  = 20'd1000000;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] agent;
        logic [31:0] ifx;
        logic [31:0] stime;
        logic [63:0] rx;
        logic [63:0] tx;
        logic [63:0] speed;
    } t_slot;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic        first;
        logic        full;
        logic [31:0] dt;
        logic [63:0] drx;
        logic [63:0] dtx;
        logic [63:0] prev_speed;
        logic [63:0] speed;
        logic [31:0] rx_tot;
        logic [31:0] tx_tot;
    } t_job;

    typedef struct packed {
        logic                 start;
        logic                 wide;   // 64-bit quotient, no saturation
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: rtl/rtu_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on rtu_pkg for the item type and the depth.
`timescale 1ns / 1ps
module rtu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rtu_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rtu_pkg::t_job o_data,
    output logic          o_empty
);
    localparam int PTR_W = (rtu_pkg::QUEUE_DEPTH > 1) ? $clog2(rtu_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rtu_pkg::QUEUE_DEPTH + 1);

    rtu_pkg::t_job r_mem [rtu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(rtu_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= (r_wptr == PTR_W'(rtu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= (r_rptr == PTR_W'(rtu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push && !o_full) - CNT_W'(i_pop && !o_empty);
        end
    end
endmodule

// File: rtl/rtu_front.sv
// Front of the rate tracker: takes an item, searches its bucket one way at a time,
// claims or updates the slot and queues the deltas. Holds the slot memories. Uses rtu_pkg.
`timescale 1ns / 1ps
module rtu_front #(
    parameter int BUCKET_BITS = 8,
    parameter int WAYS        = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [31:0]   i_agent_address,
    input  logic [31:0]   i_interface_index,
    input  logic [31:0]   i_sample_time,
    input  logic [63:0]   i_octets_received,
    input  logic [63:0]   i_octets_sent,
    input  logic [63:0]   i_link_speed,
    input  logic [31:0]   i_rx_unicast,
    input  logic [31:0]   i_rx_multicast,
    input  logic [31:0]   i_rx_broadcast,
    input  logic [31:0]   i_tx_unicast,
    input  logic [31:0]   i_tx_multicast,
    input  logic [31:0]   i_tx_broadcast,
    output logic          o_push,
    output rtu_pkg::t_job o_job,
    input  logic          i_full
);
    localparam int SLOTS  = (1 << BUCKET_BITS) * WAYS;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [2:0] F_CLEAR = 3'd0;
    localparam logic [2:0] F_IDLE  = 3'd1;
    localparam logic [2:0] F_READ  = 3'd2;
    localparam logic [2:0] F_CHECK = 3'd3;
    localparam logic [2:0] F_PUSH  = 3'd4;

    rtu_pkg::t_slot r_mem [SLOTS];
    logic           r_vmem [SLOTS];

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_clr, r_addr, r_slot;
    logic [WAY_W-1:0]  r_way;
    logic              r_hit, r_free;
    rtu_pkg::t_slot    r_rd, r_new, r_old;
    logic              r_vrd;
    logic [31:0]       r_rx_tot, r_tx_tot;

    logic              w_accept, w_match, w_last, w_store;
    logic [ADDR_W-1:0] w_base;

    assign busy     = (r_state != F_IDLE);
    assign w_accept = start && (r_state == F_IDLE);
    assign w_base   = ADDR_W'(i_agent_address[BUCKET_BITS-1:0]) * ADDR_W'(WAYS);
    assign w_match  = (r_rd.agent == r_new.agent) && (r_rd.ifx == r_new.ifx);
    assign w_last   = (r_way == WAY_W'(WAYS - 1));
    assign o_push   = (r_state == F_PUSH) && !i_full;
    assign w_store  = o_push && (r_hit || r_free);

    always_comb begin
        o_job            = '0;
        o_job.first      = !r_hit;
        o_job.full       = !r_hit && !r_free;
        o_job.speed      = r_new.speed;
        o_job.rx_tot     = r_rx_tot;
        o_job.tx_tot     = r_tx_tot;
        o_job.prev_speed = r_old.speed;
        o_job.drx        = r_new.rx - r_old.rx;
        o_job.dtx        = r_new.tx - r_old.tx;
        o_job.dt         = (r_new.stime >= r_old.stime) ? r_new.stime - r_old.stime
                                                        : r_old.stime - r_new.stime;
    end

    // Slot contents: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_slot] <= r_new;
        end
        r_rd <= r_mem[r_addr];
    end

    // Valid bits: cleared by a pass over all slots after reset.
    always_ff @(posedge i_clk) begin
        if (r_state == F_CLEAR) begin
            r_vmem[r_clr] <= 1'b0;
        end else if (w_store) begin
            r_vmem[r_slot] <= 1'b1;
        end
        r_vrd <= r_vmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new.agent <= i_agent_address;
            r_new.ifx   <= i_interface_index;
            r_new.stime <= i_sample_time;
            r_new.rx    <= i_octets_received;
            r_new.tx    <= i_octets_sent;
            r_new.speed <= i_link_speed;
            r_rx_tot    <= i_rx_unicast + i_rx_multicast + i_rx_broadcast;
            r_tx_tot    <= i_tx_unicast + i_tx_multicast + i_tx_broadcast;
        end
        if (r_state == F_CHECK && r_vrd && w_match && !r_hit) begin
            r_old <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_clr   <= '0;
            r_addr  <= '0;
            r_slot  <= '0;
            r_way   <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            unique case (r_state)
                F_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(SLOTS - 1)) begin
                        r_state <= F_IDLE;
                    end
                end
                F_IDLE: begin
                    if (w_accept) begin
                        r_addr  <= w_base;
                        r_way   <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_state <= F_READ;
                    end
                end
                F_READ: begin
                    r_state <= F_CHECK;
                end
                F_CHECK: begin
                    // A matching way wins; otherwise the lowest free way is claimed.
                    if (r_vrd) begin
                        if (w_match && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_slot <= r_addr;
                        end
                    end else if (!r_free) begin
                        r_free <= 1'b1;
                        if (!r_hit) begin
                            r_slot <= r_addr;
                        end
                    end
                    if (w_last) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_way   <= r_way + 1'b1;
                        r_state <= F_READ;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule

// File: rtl/rtu_div.sv
// Shared restoring divider, one quotient bit per cycle, with an overflow bit on top.
// Used by the back for the four rates. Uses rtu_pkg.
`timescale 1ns / 1ps
module rtu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtu_pkg::t_div_req i_req,
    output rtu_pkg::t_div_rsp o_rsp
);
    logic [rtu_pkg::DIV_NUM_W-1:0] r_rem;
    logic [rtu_pkg::DIV_DS_W-1:0]  r_ds;
    logic [rtu_pkg::DIV_Q_W-1:0]   r_q;
    logic [rtu_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_run, r_done;
    logic                          w_ge;

    assign w_ge = (r_ds[rtu_pkg::DIV_DS_W-1:rtu_pkg::DIV_NUM_W] == '0)
               && (r_rem >= r_ds[rtu_pkg::DIV_NUM_W-1:0]);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_q   <= '0;
            // The first step tests the bit just above the quotient: set means overflow.
            if (i_req.wide) begin
                r_ds  <= {i_req.den, 32'b0} << 32;
                r_cnt <= rtu_pkg::DIV_CNT_W'(65);
            end else begin
                r_ds  <= {i_req.den, 32'b0};
                r_cnt <= rtu_pkg::DIV_CNT_W'(33);
            end
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - r_ds[rtu_pkg::DIV_NUM_W-1:0];
            end
            r_q   <= {r_q[rtu_pkg::DIV_Q_W-2:0], w_ge};
            r_ds  <= r_ds >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == rtu_pkg::DIV_CNT_W'(1)) && !i_req.start;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == rtu_pkg::DIV_CNT_W'(1)) begin
                r_run <= 1'b0;
            end
        end
    end
endmodule

// File: rtl/rtu_back.sv
// Back of the rate tracker: forms the denominators, runs four rate divisions on the shared
// divider, forms the speed in Mbps by reciprocal multiplication and strobes the result.
// Depends on rtu_pkg and rtu_div.
`timescale 1ns / 1ps
module rtu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  rtu_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    output logic          o_first_sample,
    output logic          o_table_full,
    output logic [31:0]   o_load_in_pct,
    output logic [31:0]   o_load_out_pct,
    output logic [31:0]   o_rate_in_mbytes,
    output logic [31:0]   o_rate_out_mbytes,
    output logic [31:0]   o_rx_packets_total,
    output logic [31:0]   o_tx_packets_total,
    output logic [44:0]   o_speed_mbps
);
    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MUL   = 3'd1;
    localparam logic [2:0] B_MUL2  = 3'd2;
    localparam logic [2:0] B_SUM   = 3'd3;
    localparam logic [2:0] B_START = 3'd4;
    localparam logic [2:0] B_WAIT  = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    localparam logic [2:0] OP_MIN   = 3'd1;
    localparam logic [2:0] OP_MOUT  = 3'd2;
    localparam logic [2:0] OP_LIN   = 3'd3;
    localparam logic [2:0] OP_LOUT  = 3'd4;

    // Speed / 10^6 is (speed >> 6) / 15625, taken in 16-bit digits. Each digit divides a
    // value below 15625 * 2^16 through floor(x * ceil(2^44 / 15625) / 2^44), which is exact
    // over that range.
    localparam logic [29:0] MBPS_DIV   = 30'd15625;
    localparam logic [30:0] MBPS_RECIP = 31'd1125899907;

    logic [2:0]        r_state, r_op;
    rtu_pkg::t_job     r_job;
    logic [51:0]       r_dm;
    logic [63:0]       r_pl, r_ph;
    logic [95:0]       r_dl;
    logic [31:0]       r_lin, r_lout, r_min, r_mout;
    logic [47:0]       r_sp_src, r_sp_q;
    logic [13:0]       r_sp_rem;
    logic [29:0]       r_sp_x;
    logic [59:0]       r_sp_prod;
    logic [1:0]        r_sp_cnt;
    logic              r_sp_phase;
    rtu_pkg::t_div_req w_req;
    rtu_pkg::t_div_rsp w_rsp;
    logic [31:0]       w_q32;
    logic              w_no_rate, w_no_load;
    logic [29:0]       w_sp_x, w_sp_qm, w_sp_left;
    logic [15:0]       w_sp_qd;

    // Delta times 204800 = 2^17 + 2^16 + 2^13, by shifts and adds.
    function automatic logic [rtu_pkg::DIV_NUM_W-1:0] load_num(input logic [63:0] d);
        logic [rtu_pkg::DIV_NUM_W-1:0] x;
        x = {18'b0, d};
        return (x << 17) + (x << 16) + (x << 13);
    endfunction

    rtu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_req       = '0;
        w_req.start = (r_state == B_START);
        unique case (r_op)
            OP_MIN: begin
                w_req.num = {2'b0, r_job.drx, 16'b0};
                w_req.den = {44'b0, r_dm};
            end
            OP_MOUT: begin
                w_req.num = {2'b0, r_job.dtx, 16'b0};
                w_req.den = {44'b0, r_dm};
            end
            OP_LIN: begin
                w_req.num = load_num(r_job.drx);
                w_req.den = r_dl;
            end
            OP_LOUT: begin
                w_req.num = load_num(r_job.dtx);
                w_req.den = r_dl;
            end
            default: begin
                w_req.num = '0;
            end
        endcase
    end

    assign w_q32     = (w_rsp.quot[64:32] != '0) ? rtu_pkg::SAT32 : w_rsp.quot[31:0];
    assign w_no_rate = r_job.first;
    assign w_no_load = r_job.first || (r_job.prev_speed == '0);

    assign w_sp_x    = {r_sp_rem, r_sp_src[47:32]};
    assign w_sp_qd   = r_sp_prod[59:44];
    assign w_sp_qm   = {14'b0, w_sp_qd} * MBPS_DIV;
    assign w_sp_left = r_sp_x - w_sp_qm;

    assign o_pop              = (r_state == B_IDLE) && !i_empty;
    assign o_valid            = (r_state == B_OUT);
    assign o_first_sample     = r_job.first;
    assign o_table_full       = r_job.full;
    assign o_load_in_pct      = r_lin;
    assign o_load_out_pct     = r_lout;
    assign o_rate_in_mbytes   = r_min;
    assign o_rate_out_mbytes  = r_mout;
    assign o_rx_packets_total = r_job.rx_tot;
    assign o_tx_packets_total = r_job.tx_tot;
    assign o_speed_mbps       = r_sp_q[44:0];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_MUL) begin
            r_dm <= {20'b0, r_job.dt} * {32'b0, rtu_pkg::MEGA};
            r_pl <= {32'b0, r_job.dt} * {32'b0, r_job.prev_speed[31:0]};
        end
        if (r_state == B_MUL2) begin
            r_ph <= {32'b0, r_job.dt} * {32'b0, r_job.prev_speed[63:32]};
        end
        if (r_state == B_SUM) begin
            r_dl <= {32'b0, r_pl} + {r_ph, 32'b0};
        end
        if (r_state == B_WAIT && w_rsp.done) begin
            unique case (r_op)
                OP_MIN:   r_min   <= w_no_rate ? '0 : w_q32;
                OP_MOUT:  r_mout  <= w_no_rate ? '0 : w_q32;
                OP_LIN:   r_lin   <= w_no_load ? '0 : w_q32;
                OP_LOUT:  r_lout  <= w_no_load ? '0 : w_q32;
                default:  r_lout  <= r_lout;
            endcase
        end
    end

    // Speed in Mbps: the top ten bits of speed >> 6 are below the divisor and seed the
    // remainder; three digits follow, each a multiply phase then a correction phase, well inside the divisions.
    always_ff @(posedge i_clk) begin
        if (r_state == B_MUL) begin
            r_sp_rem <= {4'b0, r_job.speed[63:54]};
            r_sp_src <= r_job.speed[53:6];
            r_sp_q   <= '0;
        end else if (r_sp_cnt != '0) begin
            if (!r_sp_phase) begin
                r_sp_x    <= w_sp_x;
                r_sp_prod <= 60'({31'b0, w_sp_x} * {30'b0, MBPS_RECIP});
                r_sp_src  <= r_sp_src << 16;
            end else begin
                r_sp_rem <= w_sp_left[13:0];
                r_sp_q   <= {r_sp_q[31:0], w_sp_qd};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_cnt   <= '0;
            r_sp_phase <= 1'b0;
        end else if (r_state == B_MUL) begin
            r_sp_cnt   <= 2'd3;
            r_sp_phase <= 1'b0;
        end else if (r_sp_cnt != '0) begin
            r_sp_phase <= !r_sp_phase;
            if (r_sp_phase) begin
                r_sp_cnt <= r_sp_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_op    <= OP_MIN;
        end else begin
            unique case (r_state)
                B_IDLE:  if (!i_empty) begin
                    r_state <= B_MUL;
                end
                B_MUL:   r_state <= B_MUL2;
                B_MUL2:  r_state <= B_SUM;
                B_SUM: begin
                    r_op    <= OP_MIN;
                    r_state <= B_START;
                end
                B_START: r_state <= B_WAIT;
                B_WAIT:  if (w_rsp.done) begin
                    if (r_op == OP_LOUT) begin
                        r_state <= B_OUT;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= B_START;
                    end
                end
                B_OUT:   r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/interface_rate_tracker_unit.sv
// Interface rate tracker. The front searches the bucket of an item one way at a time; the back
// runs multiply and sum steps and four divisions on one divider, speed in Mbps formed alongside.
// The back finishes one item before it pops the next; the front can take new items meanwhile
// until the two-item queue that decouples the sides is full. Reset is synchronous; after reset
// busy stays high while the slot valid bits are cleared. No result stall.
`timescale 1ns / 1ps
module interface_rate_tracker_unit #(
    parameter int BUCKET_BITS = 8,
    parameter int WAYS        = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_agent_address,
    input  logic [31:0] i_interface_index,
    input  logic [31:0] i_sample_time,
    input  logic [63:0] i_octets_received,
    input  logic [63:0] i_octets_sent,
    input  logic [63:0] i_link_speed,
    input  logic [31:0] i_rx_unicast,
    input  logic [31:0] i_rx_multicast,
    input  logic [31:0] i_rx_broadcast,
    input  logic [31:0] i_tx_unicast,
    input  logic [31:0] i_tx_multicast,
    input  logic [31:0] i_tx_broadcast,
    output logic        o_valid,
    output logic        o_first_sample,
    output logic        o_table_full,
    output logic [31:0] o_load_in_pct,
    output logic [31:0] o_load_out_pct,
    output logic [31:0] o_rate_in_mbytes,
    output logic [31:0] o_rate_out_mbytes,
    output logic [31:0] o_rx_packets_total,
    output logic [31:0] o_tx_packets_total,
    output logic [44:0] o_speed_mbps
);
    logic          w_push, w_full, w_pop, w_empty;
    rtu_pkg::t_job w_job_in, w_job_out;

    rtu_front #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_agent_address   (i_agent_address),
        .i_interface_index (i_interface_index),
        .i_sample_time     (i_sample_time),
        .i_octets_received (i_octets_received),
        .i_octets_sent     (i_octets_sent),
        .i_link_speed      (i_link_speed),
        .i_rx_unicast      (i_rx_unicast),
        .i_rx_multicast    (i_rx_multicast),
        .i_rx_broadcast    (i_rx_broadcast),
        .i_tx_unicast      (i_tx_unicast),
        .i_tx_multicast    (i_tx_multicast),
        .i_tx_broadcast    (i_tx_broadcast),
        .o_push            (w_push),
        .o_job             (w_job_in),
        .i_full            (w_full)
    );

    rtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    rtu_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (w_empty),
        .i_job              (w_job_out),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .o_first_sample     (o_first_sample),
        .o_table_full       (o_table_full),
        .o_load_in_pct      (o_load_in_pct),
        .o_load_out_pct     (o_load_out_pct),
        .o_rate_in_mbytes   (o_rate_in_mbytes),
        .o_rate_out_mbytes  (o_rate_out_mbytes),
        .o_rx_packets_total (o_rx_packets_total),
        .o_tx_packets_total (o_tx_packets_total),
        .o_speed_mbps       (o_speed_mbps)
    );
endmodule

// File: rtl/rtu_checker.sv
// Port-level checks for the interface rate tracker, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module rtu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_first_sample,
    input logic        o_table_full,
    input logic [31:0] o_load_in_pct,
    input logic [31:0] o_load_out_pct,
    input logic [31:0] o_rate_in_mbytes,
    input logic [31:0] o_rate_out_mbytes
);
    // The result strobe lasts a single cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // An accepted item keeps the front busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after accept");

    // A full bucket never has a prior sample.
    a_full_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> o_first_sample) else $error("full without first");

    // Without a prior sample all four rates are zero.
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_first_sample) |-> (o_load_in_pct == '0 && o_load_out_pct == '0
            && o_rate_in_mbytes == '0 && o_rate_out_mbytes == '0))
        else $error("nonzero rate on first sample");

    // Coming out of reset the block is busy clearing and shows no result.
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (busy && !o_valid)) else $error("bad state after reset");
endmodule

bind interface_rate_tracker_unit rtu_checker u_rtu_checker (.*);
